[sv/wps_pkg.sv]
// Shared types, constants and helpers for the WS2812 pixel serializer.
// No dependencies; imported by ws2812_pixel_serializer.
package wps_pkg;

    // Default sizing handed to the top-level parameters
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int BITS_PER_PIXEL_DEF = 24;

    // Fixed field and register widths
    localparam int PIXEL_W = 24;   // g, r, b bytes
    localparam int WORD_W  = 32;   // shift word, sent from its top bit
    localparam int DIV_W   = 24;   // 16.8 clock divider
    localparam int ACC_W   = 25;   // divider accumulator
    localparam int LEN_W   = 5;    // phase length registers
    localparam int PCNT_W  = 4;    // phase counter
    localparam int QOUT_W  = 3;    // queued_pixels field

    localparam logic [DIV_W-1:0] DIV_MIN   = DIV_W'(256);
    localparam logic [ACC_W:0]   TICK_STEP = (ACC_W + 1)'(256);

    // Configuration register reset values
    localparam logic [DIV_W-1:0] DIV_RST   = DIV_W'(4000);
    localparam logic [LEN_W-1:0] START_RST = LEN_W'(2);
    localparam logic [LEN_W-1:0] DATA_RST  = LEN_W'(5);
    localparam logic [LEN_W-1:0] TAIL_RST  = LEN_W'(3);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CLK_DIV    = 2'd0,
        CFG_START_HIGH = 2'd1,
        CFG_DATA_PHASE = 2'd2,
        CFG_LOW_TAIL   = 2'd3
    } cfg_index_t;

    // Input word kinds
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_PUSH = 1'b1
    } opcode_t;

    // Bit engine phases
    typedef enum logic [3:0] {
        PH_FETCH = 4'b0001,
        PH_TAIL  = 4'b0010,
        PH_START = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    // Result word, packed to match m_axis_tdata[5:0]
    typedef struct packed {
        logic              engine_idle;
        logic [QOUT_W-1:0] queued_pixels;
        logic              push_accepted;
        logic              line_level;
    } result_t;

    // Phase length clamped to 1..16, minus one, as a counter load value
    function automatic logic [PCNT_W-1:0] len_to_count(input logic [LEN_W-1:0] len);
        logic [PCNT_W-1:0] cnt;
        if (len == '0)
            cnt = '0;
        else if (len > LEN_W'(16))
            cnt = '1;
        else
            cnt = PCNT_W'(len - LEN_W'(1));
        return cnt;
    endfunction

endpackage

[sv/ws2812_pixel_serializer.sv]
// WS2812 pixel serializer: pixel FIFO in a synchronous memory, fractional
// clock divider and bit engine, registered result output with skid stage.
// Depends on wps_pkg.
//
// Usage:
//   s_axis carries one word per system tick (tuser = 0) or one pixel push
//   (tuser = 1, tdata = green, red, blue from bit 0 up). Every accepted word
//   yields exactly one result word on m_axis: line level, push accepted,
//   queued pixel count and engine idle flag.
//   cfg_* writes one of four registers (divider, start, data, tail lengths);
//   it is always ready. The user must write it only while no word is in flight;
//   the block does not enforce this. Each result is registered in the output
//   register or the skid stage. Throughput: one word per cycle while s_axis_tready
//   is high; every word is handled in a single read-modify-write pass over the
//   state registers, and the head entry of the pixel memory is read ahead into a
//   register (with write forwarding), so a fetch never waits on the memory read port.
//   Reset: the FIFO empties, the engine waits in fetch with the line low,
//   and the registers return to 4000, 2, 5, 3. No clearing pass is needed.
//   Stall: when m_axis_tready is low, one more result lands in the skid
//   stage; s_axis_tready then drops until the output drains.
module ws2812_pixel_serializer
    import wps_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // green[7:0], red[15:8], blue[23:16]
    input  logic             s_axis_tuser,   // opcode[0]
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // line_level[0], push_accepted[1],
                                             // queued_pixels[4:2], engine_idle[5]
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [DIV_W-1:0] cfg_data
);

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BR_W = $clog2(BITS_PER_PIXEL + 1);
    localparam logic [QP_W-1:0] PTR_LAST = QP_W'(QUEUE_DEPTH - 1);
    localparam logic [QC_W-1:0] QC_FULL  = QC_W'(QUEUE_DEPTH);
    localparam logic [BR_W-1:0] BR_LOAD  = BR_W'(BITS_PER_PIXEL);

    // Configuration registers
    logic [DIV_W-1:0] div_reg;
    logic [LEN_W-1:0] start_len_reg;
    logic [LEN_W-1:0] data_len_reg;
    logic [LEN_W-1:0] tail_len_reg;

    // Pixel memory and its pointers
    logic [PIXEL_W-1:0] pixel_mem [QUEUE_DEPTH];
    logic [PIXEL_W-1:0] head_pix_reg;
    logic [QP_W-1:0]    head_reg, head_next;
    logic [QP_W-1:0]    tail_reg, tail_next;
    logic [QC_W-1:0]    count_reg, count_next;

    // Bit engine state
    logic [WORD_W-1:0]  shift_reg, shift_next;
    logic [BR_W-1:0]    bits_reg, bits_next;
    logic               cur_bit_reg, cur_bit_next;
    phase_t             phase_reg, phase_next;
    logic [PCNT_W-1:0]  pcnt_reg, pcnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    // Output register and skid stage
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic               in_acc;
    logic               is_push;
    logic               wr_en;
    logic [PIXEL_W-1:0] wr_pix;
    logic [DIV_W-1:0]   div_eff;
    logic [ACC_W:0]     acc_sum;
    logic               eng_fire;
    logic [WORD_W-1:0]  fetch_src;
    logic [BR_W-1:0]    fetch_bits;
    logic               line_lvl;
    result_t            res;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign is_push   = (s_axis_tuser == OP_PUSH);
    // Store the pixel as green, red, blue from the top byte down
    assign wr_pix    = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= DIV_RST;
            start_len_reg <= START_RST;
            data_len_reg  <= DATA_RST;
            tail_len_reg  <= TAIL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLK_DIV:    div_reg       <= cfg_data;
                CFG_START_HIGH: start_len_reg <= cfg_data[LEN_W-1:0];
                CFG_DATA_PHASE: data_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_LOW_TAIL:   tail_len_reg  <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance the fractional divider on a tick
    assign div_eff  = (div_reg < DIV_MIN) ? DIV_MIN : div_reg;
    assign acc_sum  = {1'b0, acc_reg} + TICK_STEP;
    assign eng_fire = in_acc && !is_push && (acc_sum >= {2'b00, div_eff});

    // Source of the next bit: current shift word or a freshly fetched pixel
    always_comb
    begin
        if (bits_reg == '0)
        begin
            fetch_src  = {head_pix_reg, {(WORD_W - PIXEL_W){1'b0}}};
            fetch_bits = BR_LOAD;
        end
        else
        begin
            fetch_src  = shift_reg;
            fetch_bits = bits_reg;
        end
    end

    // Per-word state update: push into the queue or run one engine step
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        cur_bit_next = cur_bit_reg;
        phase_next   = phase_reg;
        pcnt_next    = pcnt_reg;
        acc_next     = acc_reg;
        wr_en        = 1'b0;

        if (in_acc && is_push)
        begin
            if (count_reg < QC_FULL)
            begin
                wr_en      = 1'b1;
                tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + QP_W'(1);
                count_next = count_reg + QC_W'(1);
            end
        end
        else if (in_acc)
        begin
            acc_next = eng_fire ? ACC_W'(acc_sum - {2'b00, div_eff}) : ACC_W'(acc_sum);
        end

        if (eng_fire)
        begin
            case (phase_reg)
                PH_FETCH:
                begin
                    if (bits_reg != '0 || count_reg != '0)
                    begin
                        if (bits_reg == '0)
                        begin
                            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + QP_W'(1);
                            count_next = count_reg - QC_W'(1);
                        end
                        cur_bit_next = fetch_src[WORD_W-1];
                        shift_next   = fetch_src << 1;
                        bits_next    = fetch_bits - BR_W'(1);
                        if (len_to_count(tail_len_reg) != '0)
                        begin
                            phase_next = PH_TAIL;
                            pcnt_next  = len_to_count(tail_len_reg) - PCNT_W'(1);
                        end
                        else
                        begin
                            phase_next = PH_START;
                            pcnt_next  = len_to_count(start_len_reg);
                        end
                    end
                end
                PH_TAIL:
                begin
                    if (pcnt_reg == '0)
                    begin
                        phase_next = PH_START;
                        pcnt_next  = len_to_count(start_len_reg);
                    end
                    else
                        pcnt_next = pcnt_reg - PCNT_W'(1);
                end
                PH_START:
                begin
                    if (pcnt_reg == '0)
                    begin
                        phase_next = PH_DATA;
                        pcnt_next  = len_to_count(data_len_reg);
                    end
                    else
                        pcnt_next = pcnt_reg - PCNT_W'(1);
                end
                PH_DATA:
                begin
                    if (pcnt_reg == '0)
                    begin
                        phase_next = PH_FETCH;
                        pcnt_next  = '0;
                    end
                    else
                        pcnt_next = pcnt_reg - PCNT_W'(1);
                end
                default:
                begin
                    phase_next = PH_FETCH;
                    pcnt_next  = '0;
                end
            endcase
        end
    end

    // Build the result word from the updated state
    always_comb
    begin
        case (phase_next)
            PH_START: line_lvl = 1'b1;
            PH_DATA:  line_lvl = cur_bit_next;
            default:  line_lvl = 1'b0;
        endcase
        res.line_level    = line_lvl;
        res.push_accepted = wr_en;
        res.queued_pixels = QOUT_W'(count_next);
        res.engine_idle   = (phase_next == PH_FETCH) && (bits_next == '0) &&
                            (count_next == '0);
    end

    // Write the pixel memory; read the next head entry, forwarding a same-entry write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            pixel_mem[tail_reg] <= wr_pix;
        if (wr_en && (tail_reg == head_next))
            head_pix_reg <= wr_pix;
        else
            head_pix_reg <= pixel_mem[head_next];
    end

    // Hold queue pointers and engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            shift_reg   <= '0;
            bits_reg    <= '0;
            cur_bit_reg <= 1'b0;
            phase_reg   <= PH_FETCH;
            pcnt_reg    <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            cur_bit_reg <= cur_bit_next;
            phase_reg   <= phase_next;
            pcnt_reg    <= pcnt_next;
            acc_reg     <= acc_next;
        end
    end

    // Output register with one skid word behind it
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !m_axis_tready)
        begin
            if (in_acc)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= in_acc;
        end
        else
        begin
            out_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !m_axis_tready)
        begin
            if (in_acc)
                skid_reg <= res;
        end
        else if (skid_valid_reg)
        begin
            out_reg  <= skid_reg;
            skid_reg <= res;
        end
        else if (in_acc)
        begin
            out_reg <= res;
        end
    end

`ifndef SYNTHESIS
    // Queue never holds more pixels than the memory has entries
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QC_FULL)
        else $error("pixel queue count overflow");

    // An empty queue has its pointers together
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with split pointers");

    // Skid stage only fills behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // A push into a non-full queue grows it by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_push && (count_reg < QC_FULL)) |=>
            (count_reg == $past(count_reg) + QC_W'(1)))
        else $error("accepted push did not grow the queue");
`endif

endmodule
